// File: sv/free_hole_fit_and_coalesce_assert.svh
// Assertion macros for the free hole table.
`ifndef FREE_HOLE_FIT_AND_COALESCE_ASSERT_SVH
`define FREE_HOLE_FIT_AND_COALESCE_ASSERT_SVH
`ifndef SYNTHESIS
`define FHFC_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define FHFC_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define FHFC_ASSERT(lbl, clk, rst_n, prop, msg)
`define FHFC_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

// File: sv/fhfc_pkg.sv
// Shared types and constants of the free hole table.
`timescale 1ns / 1ps
`default_nettype none
package fhfc_pkg;
	localparam int HOLES = 64;
	localparam int IDX_W = $clog2(HOLES);
	localparam int CNT_W = $clog2(HOLES + 1);

	localparam logic [1:0] CMD_ADD         = 2'd0;
	localparam logic [1:0] CMD_FIND        = 2'd1;
	localparam logic [1:0] CMD_CONSOLIDATE = 2'd2;

	localparam logic [1:0] STRAT_BEST  = 2'd1;
	localparam logic [1:0] STRAT_WORST = 2'd2;

	typedef struct packed {
		logic [31:0] base;
		logic [31:0] size;
	} hole_t;

	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_WRITE,
		CELL_RIGHT,
		CELL_LEFT,
		CELL_HEAD
	} cell_op_t;
endpackage
`default_nettype wire

// File: sv/fhfc_cell.sv
// One cell of the hole chain: holds one hole and loads it from din, a neighbor or the head cell.
`timescale 1ns / 1ps
`default_nettype none
module fhfc_cell
	import fhfc_pkg::*;
(
	input  wire logic     clk,
	input  wire cell_op_t op,
	input  wire hole_t    din,
	input  wire hole_t    right,
	input  wire hole_t    left,
	input  wire hole_t    head,
	output hole_t         hole
);
	hole_t hole_q;

	always_ff @(posedge clk) begin
		case (op)
			CELL_WRITE: hole_q <= din;
			CELL_RIGHT: hole_q <= right;
			CELL_LEFT:  hole_q <= left;
			CELL_HEAD:  hole_q <= head;
			default:    hole_q <= hole_q;
		endcase
	end

	assign hole = hole_q;
endmodule
`default_nettype wire

// File: sv/free_hole_fit_and_coalesce.sv
// Top level of the free hole table with fit search and coalescing.
// Usage:
//   Items enter on s_* (s_tuser = command, s_tdata = hole_base, req_size).
//   Each item yields exactly one result item on m_* after its operation ends.
//   fit_strategy is written on cfg_* (always ready); the user must write it
//   only while the block is idle; the block itself does not enforce this.
// Operations, on the chain of 64 cells:
//   add          one write into the cell at the fill count
//   find         one turn of the chain, the fit unit watching the head cell
//   consolidate  one odd/even sort round per held hole, then a merge walk
//                over the head pair, one hole a cycle
// The input reopens as the result is loaded.
// One item is worked on at a time; the next item is accepted as soon as the
// current result sits in the output register, even if it is not yet taken.
// Reset clears the fill count, strategy and output valid; the cell contents
// stay undefined and are never read past the fill count.
// A stalled receiver holds the result; a finished op then waits in DONE.
`timescale 1ns / 1ps
`default_nettype none
`include "free_hole_fit_and_coalesce_assert.svh"
module free_hole_fit_and_coalesce
	import fhfc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [63:0] s_tdata,  // hole_base[31:0], req_size[63:32]
	input  wire logic [1:0]  s_tuser,  // command[1:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// chosen_index[5:0], chosen_base[37:6], chosen_size[69:38],
	// entries_used[76:70], zero[79:77]
	output logic [79:0]      m_tdata,
	output logic [1:0]       m_tuser,  // found[0], table_full[1]
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_data  // fit_strategy
);
	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_FIND  = 5'b00010,
		ST_SORT  = 5'b00100,
		ST_MERGE = 5'b01000,
		ST_DONE  = 5'b10000
	} state_t;

	state_t           state_q;
	logic [1:0]       strat_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] iter_q;   // sort round or merge holes remaining
	logic [IDX_W-1:0] step_q;
	logic [31:0]      req_q;
	logic             fnd_q;
	logic             full_q;
	logic [IDX_W-1:0] idx_q;
	hole_t            best_q;

	logic             m_tvalid_q;
	logic [79:0]      m_tdata_q;
	logic [1:0]       m_tuser_q;

	hole_t            cells [HOLES];
	cell_op_t         ops   [HOLES];
	logic             swap  [HOLES];
	hole_t            din;

	wire logic s_fire = s_tvalid && s_tready;
	wire logic out_free = !m_tvalid_q || m_tready;

	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;
	assign m_tuser   = m_tuser_q;
	assign din       = '{base: s_tdata[31:0], size: s_tdata[63:32]};

	// Merge test on the head pair: end in 33 bits, saturating sum.
	wire logic [32:0] head_end = {1'b0, cells[0].base} + {1'b0, cells[0].size};
	wire logic [32:0] pair_sum = {1'b0, cells[0].size} + {1'b0, cells[1].size};
	wire logic do_merge = (iter_q >= CNT_W'(2)) && (head_end == {1'b0, cells[1].base});
	hole_t merged;
	assign merged = '{base: cells[0].base,
	                  size: pair_sum[32] ? 32'hFFFF_FFFF : pair_sum[31:0]};

	// Fit test on the head cell during the find rotation.
	wire logic head_fit = (CNT_W'(step_q) < count_q) && (cells[0].size >= req_q);
	logic take_head;
	always_comb begin
		take_head = 1'b0;
		if (head_fit) begin
			if (!fnd_q) begin
				take_head = 1'b1;
			end else if (strat_q == STRAT_BEST) begin
				take_head = cells[0].size < best_q.size;
			end else if (strat_q == STRAT_WORST) begin
				take_head = cells[0].size > best_q.size;
			end
		end
	end

	// Per-cell control: each cell picks where its next hole comes from.
	always_comb begin
		for (int k = 0; k < HOLES; k++) begin
			swap[k] = 1'b0;
			if (k < HOLES - 1) begin
				swap[k] = (state_q == ST_SORT) && (k[0] == iter_q[0])
				          && (CNT_W'(k + 1) < count_q)
				          && (cells[k].base > cells[(k + 1) % HOLES].base);
			end
		end
		for (int k = 0; k < HOLES; k++) begin
			ops[k] = CELL_HOLD;
			case (state_q)
				ST_IDLE: begin
					if (s_fire && s_tuser == CMD_ADD && CNT_W'(k) == count_q)
						ops[k] = CELL_WRITE;
				end
				ST_FIND: ops[k] = CELL_RIGHT;
				ST_SORT: begin
					if (swap[k])
						ops[k] = CELL_RIGHT;
					else if (k > 0 && swap[(k + HOLES - 1) % HOLES])
						ops[k] = CELL_LEFT;
				end
				ST_MERGE: begin
					if (do_merge) begin
						if (k >= 1)
							ops[k] = CELL_RIGHT;
					end else if (CNT_W'(k) == count_q - CNT_W'(1)) begin
						ops[k] = CELL_HEAD;
					end else if (CNT_W'(k) < count_q - CNT_W'(1)) begin
						ops[k] = CELL_RIGHT;
					end
				end
				default: ops[k] = CELL_HOLD;
			endcase
		end
	end

	for (genvar k = 0; k < HOLES; k++) begin : g_cell
		hole_t din_k;
		// Head cell takes the merged hole when the pair coalesces.
		assign din_k = (k == 0 && state_q == ST_MERGE) ? merged : din;
		fhfc_cell u_cell (
			.clk   (clk),
			.op    ((k == 0 && state_q == ST_MERGE && do_merge) ? CELL_WRITE : ops[k]),
			.din   (din_k),
			.right (cells[(k + 1) % HOLES]),
			.left  (cells[(k + HOLES - 1) % HOLES]),
			.head  (cells[0]),
			.hole  (cells[k])
		);
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			strat_q    <= 2'd0;
			count_q    <= '0;
			iter_q     <= '0;
			step_q     <= '0;
			req_q      <= '0;
			fnd_q      <= 1'b0;
			full_q     <= 1'b0;
			idx_q      <= '0;
			best_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready)
				strat_q <= cfg_data;
			if (m_tvalid_q && m_tready)
				m_tvalid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (s_fire) begin
						fnd_q  <= 1'b0;
						full_q <= 1'b0;
						idx_q  <= '0;
						best_q <= '0;
						step_q <= '0;
						req_q  <= s_tdata[63:32];
						case (s_tuser)
							CMD_ADD: begin
								// Append at the fill count, or flag and drop.
								if (count_q < CNT_W'(HOLES))
									count_q <= count_q + CNT_W'(1);
								else
									full_q <= 1'b1;
								state_q <= ST_DONE;
							end
							CMD_FIND: state_q <= ST_FIND;
							CMD_CONSOLIDATE: begin
								iter_q  <= '0;
								state_q <= (count_q >= CNT_W'(2)) ? ST_SORT : ST_DONE;
							end
							default: state_q <= ST_DONE;
						endcase
					end
				end
				ST_FIND: begin
					if (take_head) begin
						fnd_q  <= 1'b1;
						idx_q  <= step_q;
						best_q <= cells[0];
					end
					step_q <= step_q + IDX_W'(1);
					// Full turn restores the original order.
					if (step_q == IDX_W'(HOLES - 1))
						state_q <= ST_DONE;
				end
				ST_SORT: begin
					if (iter_q == count_q - CNT_W'(1)) begin
						iter_q  <= count_q;
						state_q <= ST_MERGE;
					end else begin
						iter_q <= iter_q + CNT_W'(1);
					end
				end
				ST_MERGE: begin
					if (do_merge)
						count_q <= count_q - CNT_W'(1);
					iter_q <= iter_q - CNT_W'(1);
					if (iter_q == CNT_W'(1))
						state_q <= ST_DONE;
				end
				ST_DONE: begin
					// Hold until the output register is free.
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Result payload, loaded as the item finishes.
	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			m_tdata_q <= {3'b000, 7'(count_q), best_q.size, best_q.base, 6'(idx_q)};
			m_tuser_q <= {full_q, fnd_q};
		end
	end

	`FHFC_NEVER(a_count_max, clk, arst_n, count_q > CNT_W'(HOLES), "fill count overflow")
	`FHFC_NEVER(a_merge_rem, clk, arst_n, (state_q == ST_MERGE) && (iter_q > count_q),
		"merge walk beyond fill count")
	`FHFC_ASSERT(a_out_hold, clk, arst_n, m_tvalid_q && !m_tready |=> m_tvalid_q,
		"result dropped under stall")
	`FHFC_ASSERT(a_done_wait, clk, arst_n,
		(state_q == ST_DONE) && !out_free |=> (state_q == ST_DONE), "result overwritten")
endmodule
`default_nettype wire
